// ===== sv/sha256_pkg.sv =====
// SHA-256 package: round constants, initial hash values, round and schedule helpers.
// Used by sha256_dp, sha256_ctrl and the top level.
package sha256_pkg;

  localparam int WordW  = 32;
  localparam int Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load_byte;   // write cur_byte at fill position
    logic [7:0] cur_byte;
    logic       init_hash;   // reload initial hash values
    logic       start_round; // copy hash into working vars, load schedule
    logic       do_round;    // one compression round
    logic [5:0] round_idx;
    logic       add_hash;    // fold working vars into hash
    logic [2:0] out_sel;     // digest word select
  } dp_cmd_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ===== sv/sha256_dp.sv =====
// SHA-256 datapath: block buffer, 16-word schedule shift line, working
// variables, hash words. Depends on sha256_pkg.
module sha256_dp (
  input  logic                clk,
  input  sha256_pkg::dp_cmd_t cmd,
  input  logic [5:0]          fill,
  output logic [31:0]         digest
);
  import sha256_pkg::*;

  word_t blk [16];
  word_t w   [16];
  word_t v   [8];
  word_t h   [8];
  word_t s0, s1, w_new, big1, big0, ch, maj, t1, t2;
  word_t blk_wr;
  logic [3:0] widx;
  logic [4:0] sh;

  assign widx = fill[5:2];
  assign sh   = 5'(24 - 8 * int'(fill[1:0]));

  // word at the fill position with the current byte merged in
  assign blk_wr = (blk[widx] & ~(word_t'(8'hff) << sh)) | (word_t'(cmd.cur_byte) << sh);

  always_comb begin
    s0    = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1    = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    big1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + big1 + ch + round_k(cmd.round_idx) + w[0];
    big0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = big0 + maj;
  end

  assign digest = h[cmd.out_sel];

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      blk[widx] <= blk_wr;
    end
    if (cmd.start_round) begin
      // start comes with the byte at position 63, which lands in word 15
      for (int i = 0; i < 15; i++) w[i] <= blk[i];
      w[15] <= blk_wr;
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      for (int i = 1; i < 8; i++) begin
        if (i != 4) v[i] <= v[i-1];
      end
      v[4] <= v[3] + t1;
      v[0] <= t1 + t2;
    end
    if (cmd.init_hash) begin
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
    end else if (cmd.add_hash) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
  end
endmodule

// ===== sv/sha256_ctrl.sv =====
// SHA-256 controller: byte intake, padding sequencer, round counter, digest output.
// Depends on sha256_pkg; drives sha256_dp through dp_cmd_t.
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_present,
  input  logic                in_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_idx,
  output sha256_pkg::dp_cmd_t cmd,
  output logic [5:0]          fill
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    IDLE, PAD, ROUND, ADD, EMIT
  } state_t;

  state_t      state;
  logic [63:0] bit_count;
  logic [63:0] len;
  logic        finishing;
  logic        pad_first;
  logic [5:0]  rnd;
  logic        full;
  logic [2:0]  out_sel;
  logic        len_blk;    // current padding block carries the length
  logic        length_in;  // final padded block has gone into the rounds
  logic [7:0]  pad_byte;

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == EMIT);
  assign out_idx   = out_sel;

  // pad byte for the current fill position
  always_comb begin
    if (pad_first) pad_byte = 8'h80;
    else if (len_blk && fill >= 6'd56) pad_byte = len[8*(7 - int'(fill[2:0])) +: 8];
    else pad_byte = 8'h00;
  end

  always_comb begin
    cmd.cur_byte    = (state == IDLE) ? in_byte : pad_byte;
    cmd.load_byte   = (state == IDLE && in_valid && in_present) || (state == PAD);
    cmd.start_round = cmd.load_byte && (fill == 6'd63);
    cmd.do_round    = (state == ROUND);
    cmd.round_idx   = rnd;
    cmd.add_hash    = (state == ADD);
    cmd.init_hash   = rst || (state == EMIT && out_ready && out_sel == 3'd7);
    cmd.out_sel     = out_sel;
  end
  assign full = cmd.start_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      fill      <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      pad_first <= 1'b0;
      rnd       <= '0;
      out_sel   <= '0;
      len       <= '0;
      len_blk   <= 1'b0;
      length_in <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            if (in_present) fill <= fill + 6'd1;
            if (in_end) begin
              len       <= in_present ? bit_count + 64'd8 : bit_count;
              finishing <= 1'b1;
              pad_first <= 1'b1;
            end
            if (in_present) bit_count <= bit_count + 64'd8;
            if (full) begin
              state <= ROUND;
              rnd   <= '0;
            end else if (in_end) begin
              state <= PAD;
            end
          end
        end
        PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          // 0x80 below byte 56 leaves room for the length in this block
          if (pad_first && fill < 6'd56) len_blk <= 1'b1;
          if (fill == 6'd63) begin
            if (len_blk) length_in <= 1'b1;
            else len_blk <= 1'b1;
          end
          if (full) begin
            state <= ROUND;
            rnd   <= '0;
          end
        end
        ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'(Rounds - 1)) state <= ADD;
        end
        ADD: begin
          if (finishing && length_in) begin
            state   <= EMIT;
            out_sel <= '0;
          end else if (finishing) state <= PAD;
          else state <= IDLE;
        end
        EMIT: begin
          if (out_ready) begin
            out_sel <= out_sel + 3'd1;
            if (out_sel == 3'd7) begin
              state     <= IDLE;
              finishing <= 1'b0;
              bit_count <= '0;
              fill      <= '0;
              len_blk   <= 1'b0;
              length_in <= 1'b0;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher, top level.
// Instantiates sha256_ctrl and sha256_dp; depends on sha256_pkg.
//
// Input stream: one item per transfer; tdata carries the message byte, tuser
// marks whether the byte is present, tlast ends the message. Output stream:
// eight transfers per message, digest words most significant first, tuser
// holds the word index, tlast flags the eighth word.
// A byte is taken while the controller is idle; the 64th byte of a block
// starts 64 rounds (one round per cycle, one shared round unit), and then
// the ADD state folds the working variables into the hash. At end of
// message the padding bytes go in one per cycle and then the final block is
// compressed; if the length does not fit, two blocks are compressed.
// The input is not ready while rounds, padding or output run. The digest is
// held until the receiver takes each word; a stall just holds it.
// Reset (rst, synchronous) loads the initial hash values and clears counters.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tuser,  // [0] byte_present
  input  logic        s_tlast,  // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] digest_word
  output logic [2:0]  m_tuser,  // [2:0] word_index
  output logic        m_tlast   // last_word
);
  import sha256_pkg::*;

  dp_cmd_t    cmd;
  logic [5:0] fill;

  sha256_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
    .in_present(s_tuser), .in_end(s_tlast),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_idx(m_tuser),
    .cmd, .fill
  );

  sha256_dp u_dp (.clk, .cmd, .fill, .digest(m_tdata));

  assign m_tlast = (m_tuser == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input open while digest out");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest word index skipped");
  a_round_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.do_round |-> !s_tready) else $error("input taken during rounds");
endmodule
